// File: rtl/sdrd_pkg.sv
`timescale 1ns / 1ps

package sdrd_pkg;

    // Input word command codes.
    localparam logic [1:0] CMD_SEEK = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_RX   = 2'd2;

    // Bytes on the SPI bus.
    localparam logic [7:0] SD_CMD17    = 8'h51;
    localparam logic [7:0] SPI_FILL    = 8'hFF;
    localparam logic [7:0] DATA_TOKEN  = 8'hFE;
    localparam logic [7:0] R1_READY    = 8'h00;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    // Sector geometry.
    localparam int unsigned SECTOR_W    = 23;
    localparam int unsigned POS_W       = 10;
    localparam int unsigned OFS_BITS    = 9;
    localparam logic [10:0] BLOCK_BYTES = 11'd512;
    localparam logic [9:0]  CMD_BYTES   = 10'd6;
    localparam logic [9:0]  CRC_BYTES   = 10'd2;

    // Index of each byte of the command frame after the opcode.
    localparam logic [9:0] CMD_ADDR_HI  = 10'd1;
    localparam logic [9:0] CMD_ADDR_MID = 10'd2;
    localparam logic [9:0] CMD_ADDR_LO  = 10'd3;
    localparam logic [9:0] CMD_ADDR_LSB = 10'd4;

    typedef enum logic [7:0] {
        PH_IDLE = 8'b0000_0001,
        PH_CMD  = 8'b0000_0010,
        PH_R1   = 8'b0000_0100,
        PH_TOK  = 8'b0000_1000,
        PH_SKIP = 8'b0001_0000,
        PH_DATA = 8'b0010_0000,
        PH_TAIL = 8'b0100_0000,
        PH_CRC  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_active;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic       rejected;
    } t_result;

endpackage

// File: rtl/sd_spi_block_read_sequencer.sv
`timescale 1ns / 1ps
// A result word is registered at the edge that accepts its input word.
// Throughput: one input word per cycle while o_stall is low; the state updates on acceptance.
// A two-entry output stage (output register plus skid register) decouples the two channels;
// o_stall rises only while the skid register holds a word.
// Reset is synchronous and active low: phase idle, sector and position zero, no words held.
module sd_spi_block_read_sequencer #(
    parameter int unsigned POLL_LIMIT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_seek_offset,
    input  logic [7:0]  i_read_count,
    input  logic [7:0]  i_rx_byte,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_cs_active,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_done_res,
    output logic        o_rejected
);

    // The poll counter runs from 1 up to POLL_LIMIT.
    localparam int unsigned PW = $clog2(POLL_LIMIT + 1);
    localparam logic [PW-1:0] POLL_MAX = PW'(POLL_LIMIT);
    localparam logic [PW-1:0] POLL_ONE = PW'(1);

    // Sequencer state.
    sdrd_pkg::t_phase                    r_phase, n_phase;
    logic [sdrd_pkg::SECTOR_W-1:0]       r_sector, n_sector;
    logic [sdrd_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [9:0]                          r_byte_cnt, n_byte_cnt;
    logic [PW-1:0]                       r_poll, n_poll;
    logic [7:0]                          r_pending, n_pending;

    // Output stage.
    logic                r_out_valid;
    sdrd_pkg::t_result   r_out;
    logic                r_skid_valid;
    sdrd_pkg::t_result   r_skid;

    sdrd_pkg::t_result   res;
    logic                accept_in;
    logic                out_free;
    logic                busy;
    logic [10:0]         used;
    logic [9:0]          tail_len;
    logic [9:0]          pos_sum;

    assign o_stall   = r_skid_valid;
    assign accept_in = i_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_stall;
    assign busy      = (r_phase != sdrd_pkg::PH_IDLE);

    // Bytes left in the block after the skipped prefix and the requested data.
    // A position already past the block leaves no tail at all.
    assign used     = {1'b0, r_pos} + {3'b000, r_pending};
    assign tail_len = (used < sdrd_pkg::BLOCK_BYTES) ?
                      10'(sdrd_pkg::BLOCK_BYTES - used) : 10'd0;
    assign pos_sum  = 10'({1'b0, r_pos} + {3'b000, r_pending});

    // Enter a phase of the data part, passing over any phase of zero length.
    function automatic sdrd_pkg::t_phase f_enter(
        input sdrd_pkg::t_phase ph,
        input logic [9:0]       pos,
        input logic [7:0]       pend,
        input logic [9:0]       tail
    );
        sdrd_pkg::t_phase p;
        p = ph;
        if (p == sdrd_pkg::PH_SKIP && pos == 10'd0) p = sdrd_pkg::PH_DATA;
        if (p == sdrd_pkg::PH_DATA && pend == 8'd0) p = sdrd_pkg::PH_TAIL;
        if (p == sdrd_pkg::PH_TAIL && tail == 10'd0) p = sdrd_pkg::PH_CRC;
        return p;
    endfunction

    // Command frame: opcode, 32-bit byte address (sector << 9), then a filler.
    function automatic logic [7:0] f_cmd_byte(
        input logic [9:0]                    k,
        input logic [sdrd_pkg::SECTOR_W-1:0] sec
    );
        logic [7:0] b;
        case (k)
            sdrd_pkg::CMD_ADDR_HI:  b = sec[22:15];
            sdrd_pkg::CMD_ADDR_MID: b = sec[14:7];
            sdrd_pkg::CMD_ADDR_LO:  b = {sec[6:0], 1'b0};
            sdrd_pkg::CMD_ADDR_LSB: b = sdrd_pkg::ZERO_BYTE;
            default:                b = sdrd_pkg::SPI_FILL;
        endcase
        return b;
    endfunction

    always_comb begin
        n_phase    = r_phase;
        n_sector   = r_sector;
        n_pos      = r_pos;
        n_byte_cnt = r_byte_cnt;
        n_poll     = r_poll;
        n_pending  = r_pending;
        res        = '0;

        if (i_cmd inside {sdrd_pkg::CMD_SEEK, sdrd_pkg::CMD_READ}) begin
            if (busy) begin
                // A seek or read during a running sequence is refused.
                res.rejected = 1'b1;
            end else if (i_cmd == sdrd_pkg::CMD_SEEK) begin
                n_sector = i_seek_offset[31:sdrd_pkg::OFS_BITS];
                n_pos    = {1'b0, i_seek_offset[sdrd_pkg::OFS_BITS-1:0]};
            end else begin
                n_pending    = i_read_count;
                n_phase      = sdrd_pkg::PH_CMD;
                n_byte_cnt   = 10'd1;
                res.tx_valid = 1'b1;
                res.tx_byte  = sdrd_pkg::SD_CMD17;
            end
        end else if (i_cmd == sdrd_pkg::CMD_RX && busy) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = sdrd_pkg::SPI_FILL;
            case (r_phase)
                sdrd_pkg::PH_CMD: begin
                    if (r_byte_cnt < sdrd_pkg::CMD_BYTES) begin
                        res.tx_byte = f_cmd_byte(r_byte_cnt, r_sector);
                        n_byte_cnt  = r_byte_cnt + 10'd1;
                    end else begin
                        n_phase = sdrd_pkg::PH_R1;
                        n_poll  = POLL_ONE;
                    end
                end
                sdrd_pkg::PH_R1: begin
                    // Give up waiting for R1 after the poll limit and carry on.
                    if (i_rx_byte == sdrd_pkg::R1_READY || r_poll >= POLL_MAX) begin
                        n_phase = sdrd_pkg::PH_TOK;
                        n_poll  = POLL_ONE;
                    end else begin
                        n_poll = r_poll + POLL_ONE;
                    end
                end
                sdrd_pkg::PH_TOK: begin
                    if (i_rx_byte == sdrd_pkg::DATA_TOKEN || r_poll >= POLL_MAX) begin
                        n_phase    = f_enter(sdrd_pkg::PH_SKIP, r_pos, r_pending, tail_len);
                        n_byte_cnt = 10'd1;
                    end else begin
                        n_poll = r_poll + POLL_ONE;
                    end
                end
                sdrd_pkg::PH_SKIP: begin
                    if (r_byte_cnt < r_pos) begin
                        n_byte_cnt = r_byte_cnt + 10'd1;
                    end else begin
                        n_phase    = f_enter(sdrd_pkg::PH_DATA, r_pos, r_pending, tail_len);
                        n_byte_cnt = 10'd1;
                    end
                end
                sdrd_pkg::PH_DATA: begin
                    res.data_valid = 1'b1;
                    res.data_byte  = i_rx_byte;
                    if (r_byte_cnt < {2'b00, r_pending}) begin
                        n_byte_cnt = r_byte_cnt + 10'd1;
                    end else begin
                        n_phase    = f_enter(sdrd_pkg::PH_TAIL, r_pos, r_pending, tail_len);
                        n_byte_cnt = 10'd1;
                    end
                end
                sdrd_pkg::PH_TAIL: begin
                    if (r_byte_cnt < tail_len) begin
                        n_byte_cnt = r_byte_cnt + 10'd1;
                    end else begin
                        n_phase    = sdrd_pkg::PH_CRC;
                        n_byte_cnt = 10'd1;
                    end
                end
                sdrd_pkg::PH_CRC: begin
                    if (r_byte_cnt < sdrd_pkg::CRC_BYTES) begin
                        n_byte_cnt = r_byte_cnt + 10'd1;
                    end else begin
                        // Sequence ends: release chip select and advance the position.
                        // Only a position of exactly one block rolls into the next sector.
                        res.tx_valid = 1'b0;
                        res.tx_byte  = sdrd_pkg::ZERO_BYTE;
                        res.done_res = 1'b1;
                        n_phase      = sdrd_pkg::PH_IDLE;
                        n_byte_cnt   = 10'd0;
                        if (pos_sum == 10'(sdrd_pkg::BLOCK_BYTES)) begin
                            n_pos    = 10'd0;
                            n_sector = r_sector + 23'd1;
                        end else begin
                            n_pos = pos_sum;
                        end
                    end
                end
                default: begin
                    n_phase = sdrd_pkg::PH_IDLE;
                end
            endcase
        end

        // Chip select follows the phase the block is left in.
        res.cs_active = (n_phase != sdrd_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sdrd_pkg::PH_IDLE;
            r_sector   <= '0;
            r_pos      <= '0;
            r_byte_cnt <= '0;
            r_poll     <= '0;
            r_pending  <= '0;
        end else if (accept_in) begin
            r_phase    <= n_phase;
            r_sector   <= n_sector;
            r_pos      <= n_pos;
            r_byte_cnt <= n_byte_cnt;
            r_poll     <= n_poll;
            r_pending  <= n_pending;
        end
    end

    // Output register with a skid register behind it. A new word is taken only
    // while the skid register is empty, so no result is ever dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept_in;
            end
        end else if (accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept_in) begin
                r_out <= res;
            end
        end else if (accept_in) begin
            r_skid <= res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tx_valid   = r_out.tx_valid;
    assign o_tx_byte    = r_out.tx_byte;
    assign o_cs_active  = r_out.cs_active;
    assign o_data_valid = r_out.data_valid;
    assign o_data_byte  = r_out.data_byte;
    assign o_done_res   = r_out.done_res;
    assign o_rejected   = r_out.rejected;

    // The skid register only fills behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the output register is empty");

    // The last word of a sequence drops chip select and requests no transfer.
    a_done_releases_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (!o_cs_active && !o_tx_valid))
        else $error("done word with chip select or transfer still active");

    // Data bytes are only delivered inside a running sequence that clocks on.
    a_data_in_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data_valid) |-> (o_cs_active && o_tx_valid))
        else $error("data byte delivered outside an active transfer");

    // A refused request never starts a transfer and leaves the card selected.
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (!o_tx_valid && o_cs_active && !o_done_res))
        else $error("rejected word carries activity");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

    // The unused command code. The block must leave its state alone and only show chip select.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned SEQ_POLL_LIMIT = 10;
    localparam int RANDOM_WORDS  = 1550;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIRECTED_ROWS = 18;

    // These are results that can be written down without running the sequence.
    localparam sdrd_pkg::t_result QUIET     = '0;
    localparam sdrd_pkg::t_result REFUSED   = '{1'b0, sdrd_pkg::ZERO_BYTE, 1'b1, 1'b0,
                                                sdrd_pkg::ZERO_BYTE, 1'b0, 1'b1};
    localparam sdrd_pkg::t_result CS_HELD   = '{1'b0, sdrd_pkg::ZERO_BYTE, 1'b1, 1'b0,
                                                sdrd_pkg::ZERO_BYTE, 1'b0, 1'b0};
    localparam sdrd_pkg::t_result READ_OPEN = '{1'b1, sdrd_pkg::SD_CMD17, 1'b1, 1'b0,
                                                sdrd_pkg::ZERO_BYTE, 1'b0, 1'b0};

    // This is one row of the directed table. Rows without a typed result are checked
    // against the sequence predictor instead.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [31:0]       ofs;
        logic [7:0]        cnt;
        logic [7:0]        rx;
        logic              typed;
        sdrd_pkg::t_result want;
    } t_stim_row;

    // The directed opening runs as follows. First come words that must do nothing in the idle
    // state. Then two seeks at the top of the card, the last one leaving sector 0x7FFFFF at
    // position 257. A 255-byte read from there ends exactly on the block boundary, so the
    // position wraps to zero and the sector index wraps around its 23 bits. While that read
    // runs, a read and a seek are refused and the unused code only shows chip select. Then the
    // command frame, the R1 poll and the token poll are walked by hand. The random part carries
    // the read to its end.
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'hFF, 1'b1, QUIET},
        '{CMD_UNUSED,         32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, QUIET},
        '{sdrd_pkg::CMD_SEEK, 32'hFFFF_FFFF, 8'h00, 8'h00, 1'b1, QUIET},
        '{sdrd_pkg::CMD_SEEK, 32'hFFFF_FF01, 8'h00, 8'h00, 1'b1, QUIET},
        '{sdrd_pkg::CMD_READ, 32'h0000_0000, 8'hFF, 8'h00, 1'b1, READ_OPEN},
        '{sdrd_pkg::CMD_READ, 32'hFFFF_FFFF, 8'h00, 8'h00, 1'b1, REFUSED},
        '{sdrd_pkg::CMD_SEEK, 32'h0000_0000, 8'h00, 8'h00, 1'b1, REFUSED},
        '{CMD_UNUSED,         32'h0000_0000, 8'h00, 8'h00, 1'b1, CS_HELD},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'hFF, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'h00, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'hFF, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'h00, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'hFF, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'hFF, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'h55, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'h00, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'h12, 1'b0, QUIET},
        '{sdrd_pkg::CMD_RX,   32'h0000_0000, 8'h00, 8'hFE, 1'b0, QUIET}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = sdrd_pkg::CMD_SEEK;
    logic [31:0] i_seek_offset = '0;
    logic [7:0]  i_read_count = '0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_cs_active;
    logic        o_data_valid;
    logic [7:0]  o_data_byte;
    logic        o_done_res;
    logic        o_rejected;

    always #6 i_clk = ~i_clk;

    sd_spi_block_read_sequencer #(
        .POLL_LIMIT(SEQ_POLL_LIMIT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_seek_offset(i_seek_offset),
        .i_read_count (i_read_count),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_cs_active  (o_cs_active),
        .o_data_valid (o_data_valid),
        .o_data_byte  (o_data_byte),
        .o_done_res   (o_done_res),
        .o_rejected   (o_rejected)
    );

    // Idle rates of the two channels, in percent. The stimulus process changes them by phase.
    int send_gap_pct   = 25;
    int recv_stall_pct = 82;

    int failures       = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int reads_finished = 0;
    int data_bytes     = 0;
    int refusals       = 0;

    // Expected result words, oldest first. One is pushed for every accepted input word.
    sdrd_pkg::t_result spi_result_q[$];

    // ------------------------------------------------------------------------
    // Sequence predictor: a private copy of the read sequencer state.
    // ------------------------------------------------------------------------
    sdrd_pkg::t_phase seq_phase  = sdrd_pkg::PH_IDLE;
    logic [22:0]      seq_sector = '0;
    logic [9:0]       seq_pos    = '0;
    logic [9:0]       seq_count  = '0;
    int unsigned      seq_tries  = 0;
    logic [7:0]       seq_len    = '0;

    // The tail is the part of the block after the requested bytes. It is empty once the
    // position plus the length reaches the block size.
    function automatic logic [10:0] tail_bytes();
        logic [10:0] used;
        used = {1'b0, seq_pos} + {3'b0, seq_len};
        return (used < sdrd_pkg::BLOCK_BYTES) ? sdrd_pkg::BLOCK_BYTES - used : 11'd0;
    endfunction

    // Enters a part of the sequence. Parts of zero length are passed over, and the
    // entering word itself already counts as the first transfer of the part.
    function automatic void open_part(input sdrd_pkg::t_phase ph);
        sdrd_pkg::t_phase nxt;
        nxt = ph;
        if (nxt == sdrd_pkg::PH_SKIP && seq_pos == '0) nxt = sdrd_pkg::PH_DATA;
        if (nxt == sdrd_pkg::PH_DATA && seq_len == '0) nxt = sdrd_pkg::PH_TAIL;
        if (nxt == sdrd_pkg::PH_TAIL && tail_bytes() == '0) nxt = sdrd_pkg::PH_CRC;
        seq_phase = nxt;
        seq_count = 10'd1;
    endfunction

    // These are the CMD17 frame bytes after the opcode. The argument is the byte address
    // (sector << 9) sent MSB first, and the frame ends with a dummy CRC of 0xFF.
    function automatic logic [7:0] frame_byte(input logic [9:0] k);
        case (k)
            sdrd_pkg::CMD_ADDR_HI:  return seq_sector[22:15];
            sdrd_pkg::CMD_ADDR_MID: return seq_sector[14:7];
            sdrd_pkg::CMD_ADDR_LO:  return {seq_sector[6:0], 1'b0};
            sdrd_pkg::CMD_ADDR_LSB: return sdrd_pkg::ZERO_BYTE;
            default:                return sdrd_pkg::SPI_FILL;
        endcase
    endfunction

    function automatic sdrd_pkg::t_result predict_transfer(input logic [1:0] cmd,
                                                           input logic [31:0] ofs,
                                                           input logic [7:0] cnt,
                                                           input logic [7:0] rx);
        sdrd_pkg::t_result r;
        logic              busy;
        r = '0;
        busy = (seq_phase != sdrd_pkg::PH_IDLE);
        if (cmd == sdrd_pkg::CMD_SEEK || cmd == sdrd_pkg::CMD_READ) begin
            if (busy) begin
                r.rejected = 1'b1;
            end else if (cmd == sdrd_pkg::CMD_SEEK) begin
                seq_sector = ofs[31:9];
                seq_pos = {1'b0, ofs[8:0]};
            end else begin
                seq_len = cnt;
                seq_phase = sdrd_pkg::PH_CMD;
                seq_count = 10'd1;
                r.tx_valid = 1'b1;
                r.tx_byte = sdrd_pkg::SD_CMD17;
            end
        end else if (cmd == sdrd_pkg::CMD_RX && busy) begin
            r.tx_valid = 1'b1;
            r.tx_byte = sdrd_pkg::SPI_FILL;
            case (seq_phase)
                sdrd_pkg::PH_CMD: begin
                    if (seq_count < sdrd_pkg::CMD_BYTES) begin
                        r.tx_byte = frame_byte(seq_count);
                        seq_count++;
                    end else begin
                        seq_phase = sdrd_pkg::PH_R1;
                        seq_tries = 1;
                    end
                end
                sdrd_pkg::PH_R1: begin
                    // A poll that runs out moves on silently, as if the card had answered.
                    if (rx == sdrd_pkg::R1_READY || seq_tries >= SEQ_POLL_LIMIT) begin
                        seq_phase = sdrd_pkg::PH_TOK;
                        seq_tries = 1;
                    end else begin
                        seq_tries++;
                    end
                end
                sdrd_pkg::PH_TOK: begin
                    if (rx == sdrd_pkg::DATA_TOKEN || seq_tries >= SEQ_POLL_LIMIT)
                        open_part(sdrd_pkg::PH_SKIP);
                    else seq_tries++;
                end
                sdrd_pkg::PH_SKIP: begin
                    if (seq_count < seq_pos) seq_count++;
                    else open_part(sdrd_pkg::PH_DATA);
                end
                sdrd_pkg::PH_DATA: begin
                    r.data_valid = 1'b1;
                    r.data_byte = rx;
                    if (seq_count < {2'b0, seq_len}) seq_count++;
                    else open_part(sdrd_pkg::PH_TAIL);
                end
                sdrd_pkg::PH_TAIL: begin
                    if ({1'b0, seq_count} < tail_bytes()) seq_count++;
                    else open_part(sdrd_pkg::PH_CRC);
                end
                default: begin
                    if (seq_count < sdrd_pkg::CRC_BYTES) begin
                        seq_count++;
                    end else begin
                        // Chip select drops and the position moves on. Only a position of
                        // exactly one block wraps into the next sector.
                        r.tx_valid = 1'b0;
                        r.tx_byte = sdrd_pkg::ZERO_BYTE;
                        r.done_res = 1'b1;
                        seq_phase = sdrd_pkg::PH_IDLE;
                        seq_count = '0;
                        seq_pos = seq_pos + {2'b0, seq_len};
                        if ({1'b0, seq_pos} == sdrd_pkg::BLOCK_BYTES) begin
                            seq_pos = '0;
                            seq_sector = seq_sector + 23'd1;
                        end
                    end
                end
            endcase
        end
        r.cs_active = (seq_phase != sdrd_pkg::PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input channel. Each call presents one word and returns at the edge that takes it.
    // Handshake signals are looked at on the falling edge, where every one of them is
    // stable.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] ofs,
                             input logic [7:0] cnt, input logic [7:0] rx,
                             input logic typed, input sdrd_pkg::t_result want);
        sdrd_pkg::t_result pred;
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_seek_offset <= ofs;
        i_read_count  <= cnt;
        i_rx_byte     <= rx;
        do @(negedge i_clk); while (o_stall);
        // The word goes in at the next rising edge. The predictor always runs, so that its
        // state stays in step, even where the table gives the result.
        pred = predict_transfer(cmd, ofs, cnt, rx);
        spi_result_q.push_back(typed ? want : pred);
        @(posedge i_clk);
        words_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stall, plus a check of every word that is taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(negedge i_clk) begin
        sdrd_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (spi_result_q.size() == 0) begin
                $error("result word arrived with nothing expected");
                failures++;
            end else begin
                want = spi_result_q.pop_front();
                check_field("tx_valid", 8'(want.tx_valid), 8'(o_tx_valid));
                check_field("tx_byte", want.tx_byte, o_tx_byte);
                check_field("cs_active", 8'(want.cs_active), 8'(o_cs_active));
                check_field("data_valid", 8'(want.data_valid), 8'(o_data_valid));
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("done_res", 8'(want.done_res), 8'(o_done_res));
                check_field("rejected", 8'(want.rejected), 8'(o_rejected));
                results_seen++;
                if (want.done_res) reads_finished++;
                if (want.data_valid) data_bytes++;
                if (want.rejected) refusals++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        logic [1:0]  cmd;
        logic [31:0] ofs;
        logic [7:0]  cnt;
        logic [7:0]  rx;
        int          roll;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_word(DIRECTED[i].cmd, DIRECTED[i].ofs, DIRECTED[i].cnt, DIRECTED[i].rx,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end

        // The random part is mostly well-formed: when idle, it seeks and starts reads, and
        // while busy it feeds received bytes. Stray seeks, reads and unused codes are mixed
        // in as noise. Seek positions often land in the upper half of the block, so that a read
        // often ends exactly on the boundary or runs past it. A run past the boundary leaves
        // the position above the block for the next read.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                send_gap_pct = 82;
                recv_stall_pct = 25;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            roll = $urandom_range(99);
            ofs = $urandom;
            cnt = 8'($urandom);
            rx = 8'($urandom);
            if (seq_phase == sdrd_pkg::PH_IDLE) begin
                if (roll < 30) begin
                    cmd = sdrd_pkg::CMD_SEEK;
                    case ($urandom_range(2))
                        0: ofs[8:0] = 9'($urandom_range(511, 257));
                        1: ofs[8:0] = '0;
                        default: ;
                    endcase
                end else if (roll < 90) begin
                    cmd = sdrd_pkg::CMD_READ;
                    case ($urandom_range(7))
                        0: cnt = 8'd0;
                        1: cnt = 8'd255;
                        2, 3: begin
                            if (seq_pos >= 10'd257 && seq_pos <= 10'd511)
                                cnt = 8'(sdrd_pkg::BLOCK_BYTES - {1'b0, seq_pos});
                        end
                        default: ;
                    endcase
                end else if (roll < 95) begin
                    cmd = sdrd_pkg::CMD_RX;
                end else begin
                    cmd = CMD_UNUSED;
                end
            end else begin
                if (roll < 93) begin
                    cmd = sdrd_pkg::CMD_RX;
                    // The card answers about one poll in eight, so some polls run out.
                    if (seq_phase == sdrd_pkg::PH_R1 && $urandom_range(7) == 0)
                        rx = sdrd_pkg::R1_READY;
                    if (seq_phase == sdrd_pkg::PH_TOK && $urandom_range(7) == 0)
                        rx = sdrd_pkg::DATA_TOKEN;
                end else if (roll < 95) begin
                    cmd = sdrd_pkg::CMD_SEEK;
                end else if (roll < 97) begin
                    cmd = sdrd_pkg::CMD_READ;
                end else begin
                    cmd = CMD_UNUSED;
                end
            end
            send_word(cmd, ofs, cnt, rx, 1'b0, QUIET);
        end

        i_valid <= 1'b0;
        while (spi_result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d input words and %0d result words under three idle patterns.",
                 words_sent, results_seen);
        $display("Block reads finished: %0d, data bytes passed: %0d, busy requests refused: %0d.",
                 reads_finished, data_bytes, refusals);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog. A correct run takes well under a tenth of this time.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
